// ===== design/brc_pkg.sv =====
package brc_pkg;

	localparam int TIME_BITS_DEF = 48;
	localparam int FIELD_T_W     = 48;
	localparam int RETRY_W       = 24;
	localparam int DELAY_W       = 48;
	localparam int TALLY_W       = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 24;
	localparam int SHIFT_LIMIT   = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_USE_SIM   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_MS    = 2'd2;

	localparam logic [RETRY_W-1:0] FIRST_MS_RST = 24'd500;
	localparam logic [RETRY_W-1:0] MAX_MS_RST   = 24'd30000;

	localparam logic [1:0] EK_UNAVAIL = 2'd0;
	localparam logic [1:0] EK_OPFAIL  = 2'd1;

	typedef enum logic [1:0] {
		CMD_POLL     = 2'd0,
		CMD_FAIL     = 2'd1,
		CMD_RECREATE = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		PH_STARTING = 2'd0,
		PH_WAITING  = 2'd1,
		PH_READY    = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		DT_NONE        = 3'd0,
		DT_SIM_UNAVAIL = 3'd1,
		DT_SIM_RUNNING = 3'd2,
		DT_HW_LOST     = 3'd3,
		DT_LOOKING     = 3'd4,
		DT_NO_HW       = 3'd5,
		DT_NO_DEVICES  = 3'd6,
		DT_HW_READY    = 3'd7
	} detail_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [FIELD_T_W-1:0] now_ms;
		logic                 created_ok;
		logic                 devices_found;
		logic [1:0]           error_kind;
	} event_t;

	typedef struct packed {
		logic                 ready_res;
		logic [1:0]           phase;
		logic [2:0]           detail_code;
		logic [TALLY_W-1:0]   attempt_count;
		logic                 factory_asked;
		logic [FIELD_T_W-1:0] retry_at_ms;
	} result_t;

endpackage

// ===== design/brc_delay.sv =====
module brc_delay (
	input  logic [brc_pkg::RETRY_W-1:0] first_ms,
	input  logic [brc_pkg::RETRY_W-1:0] max_ms,
	input  logic [brc_pkg::TALLY_W-1:0] tally,
	output logic [brc_pkg::DELAY_W-1:0] delay_ms
);

	logic                        long_run;
	logic [brc_pkg::DELAY_W-1:0] shifted;
	logic [brc_pkg::DELAY_W-1:0] base;
	logic [brc_pkg::DELAY_W-1:0] cap;

	// tally here is the count before the bump, i.e. the number of doublings
	assign long_run = (|tally[brc_pkg::TALLY_W-1:5]) ||
		(tally[4:0] >= 5'(brc_pkg::SHIFT_LIMIT));
	assign base     = brc_pkg::DELAY_W'(first_ms);
	assign cap      = brc_pkg::DELAY_W'(max_ms);
	assign shifted  = base << tally[4:0];

	always_comb begin
		if (first_ms == '0) begin
			delay_ms = '0;
		end else if (tally == '0) begin
			delay_ms = base;
		end else if (long_run || (shifted >= cap)) begin
			delay_ms = cap;
		end else begin
			delay_ms = shifted;
		end
	end

endmodule

// ===== design/brc_core.sv =====
module brc_core #(
	parameter int TIME_BITS = brc_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           adv,
	input  brc_pkg::event_t                ev,
	output brc_pkg::result_t               res
);

	logic                        sim_q;
	logic [brc_pkg::RETRY_W-1:0] first_q;
	logic [brc_pkg::RETRY_W-1:0] max_q;

	logic                        held_q, held_n;
	logic                        armed_q, armed_n;
	logic [TIME_BITS-1:0]        due_q, due_n;
	logic [brc_pkg::TALLY_W-1:0] tally_q, tally_n, tally_inc;
	brc_pkg::phase_t             phase_q, phase_n;
	brc_pkg::detail_t            detail_q, detail_n;
	logic                        asked;

	logic [63:0]                 now64;
	logic [TIME_BITS-1:0]        now_t;
	logic [brc_pkg::DELAY_W-1:0] delay_poll;
	logic [63:0]                 sum_poll;
	logic [63:0]                 sum_drop;
	logic [63:0]                 due64_n;
	brc_pkg::result_t            res_n;
	brc_pkg::result_t            res_q;

	brc_delay u_delay (
		.first_ms (first_q),
		.max_ms   (max_q),
		.tally    (tally_q),
		.delay_ms (delay_poll)
	);

	assign now64     = 64'(ev.now_ms);
	assign now_t     = now64[TIME_BITS-1:0];
	assign sum_poll  = 64'(now_t) + 64'(delay_poll);
	assign sum_drop  = 64'(now_t) + 64'(first_q);
	assign tally_inc = (&tally_q) ? tally_q : tally_q + 1'b1;

	always_comb begin
		held_n   = held_q;
		armed_n  = armed_q;
		due_n    = due_q;
		tally_n  = tally_q;
		phase_n  = phase_q;
		detail_n = detail_q;
		asked    = 1'b0;
		unique case (ev.cmd)
			brc_pkg::CMD_POLL: begin
				if (!held_q && !(armed_q && (now_t < due_q))) begin
					asked   = 1'b1;
					armed_n = 1'b0;
					if (sim_q && ev.created_ok) begin
						held_n   = 1'b1;
						tally_n  = '0;
						phase_n  = brc_pkg::PH_READY;
						detail_n = brc_pkg::DT_SIM_RUNNING;
					end else if (!sim_q && ev.created_ok && ev.devices_found) begin
						held_n   = 1'b1;
						tally_n  = '0;
						phase_n  = brc_pkg::PH_READY;
						detail_n = brc_pkg::DT_HW_READY;
					end else begin
						tally_n = tally_inc;
						phase_n = brc_pkg::PH_WAITING;
						armed_n = 1'b1;
						due_n   = sum_poll[TIME_BITS-1:0];
						if (sim_q) begin
							detail_n = brc_pkg::DT_SIM_UNAVAIL;
						end else if (!ev.created_ok) begin
							detail_n = brc_pkg::DT_NO_HW;
						end else begin
							detail_n = brc_pkg::DT_NO_DEVICES;
						end
					end
				end
			end
			brc_pkg::CMD_FAIL, brc_pkg::CMD_RECREATE: begin
				if (ev.cmd == brc_pkg::CMD_RECREATE ||
						ev.error_kind == brc_pkg::EK_UNAVAIL ||
						ev.error_kind == brc_pkg::EK_OPFAIL) begin
					held_n   = 1'b0;
					tally_n  = '0;
					phase_n  = brc_pkg::PH_WAITING;
					armed_n  = 1'b1;
					due_n    = sum_drop[TIME_BITS-1:0];
					detail_n = (ev.cmd == brc_pkg::CMD_RECREATE) ?
						brc_pkg::DT_LOOKING : brc_pkg::DT_HW_LOST;
				end
			end
			default: begin
			end
		endcase
	end

	assign due64_n = 64'(due_n);

	always_comb begin
		res_n.ready_res     = held_n;
		res_n.phase         = phase_n;
		res_n.detail_code   = detail_n;
		res_n.attempt_count = tally_n;
		res_n.factory_asked = asked;
		res_n.retry_at_ms   = armed_n ? due64_n[brc_pkg::FIELD_T_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sim_q   <= 1'b0;
			first_q <= brc_pkg::FIRST_MS_RST;
			max_q   <= brc_pkg::MAX_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				brc_pkg::CFG_USE_SIM:  sim_q   <= cfg_data[0];
				brc_pkg::CFG_FIRST_MS: first_q <= cfg_data;
				brc_pkg::CFG_MAX_MS:   max_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= 1'b0;
			armed_q  <= 1'b0;
			due_q    <= '0;
			tally_q  <= '0;
			phase_q  <= brc_pkg::PH_STARTING;
			detail_q <= brc_pkg::DT_NONE;
		end else if (adv) begin
			held_q   <= held_n;
			armed_q  <= armed_n;
			due_q    <= due_n;
			tally_q  <= tally_n;
			phase_q  <= phase_n;
			detail_q <= detail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_n;
		end
	end

	assign res = res_q;

endmodule

// ===== design/backoff_reconnect_controller_unit.sv =====
// Backoff reconnect controller.
// Input channel (in_valid/in_ready) carries one event beat: cmd, now_ms and
// the poll/failure qualifiers. Output channel (out_valid/out_ready) returns
// exactly one result beat per event, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 use_simulation, 1 first_retry_ms, 2 max_retry_ms); write only while idle.
// Flow: an accepted event is registered, then evaluated against the
// connection state and its result registered once the output register is
// free. Throughput is one event per cycle while out_ready holds, bounded by
// the combinational state update loop (delay shift, compare and time add).
// When the receiver stalls, the result register holds and the input register
// still takes one more beat; in_ready drops only when both are full.
// Reset (arst_n low) empties both registers, clears the connection state to
// starting and restores the register defaults (500 ms first, 30000 ms cap).
module backoff_reconnect_controller_unit #(
	parameter int TIME_BITS = brc_pkg::TIME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [brc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     cmd,
	input  logic [brc_pkg::FIELD_T_W-1:0]  now_ms,
	input  logic                           created_ok,
	input  logic                           devices_found,
	input  logic [1:0]                     error_kind,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           ready_res,
	output logic [1:0]                     phase,
	output logic [2:0]                     detail_code,
	output logic [brc_pkg::TALLY_W-1:0]    attempt_count,
	output logic                           factory_asked,
	output logic [brc_pkg::FIELD_T_W-1:0]  retry_at_ms
);

	logic             v_s1;
	brc_pkg::event_t  ev_s1;
	logic             out_valid_q;
	logic             adv;
	brc_pkg::result_t res;

	assign adv      = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ev_s1.cmd           <= cmd;
			ev_s1.now_ms        <= now_ms;
			ev_s1.created_ok    <= created_ok;
			ev_s1.devices_found <= devices_found;
			ev_s1.error_kind    <= error_kind;
		end
	end

	brc_core #(
		.TIME_BITS (TIME_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.ev        (ev_s1),
		.res       (res)
	);

	assign out_valid     = out_valid_q;
	assign ready_res     = res.ready_res;
	assign phase         = res.phase;
	assign detail_code   = res.detail_code;
	assign attempt_count = res.attempt_count;
	assign factory_asked = res.factory_asked;
	assign retry_at_ms   = res.retry_at_ms;

endmodule

// ===== design/brc_chk.sv =====
module brc_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_we,
	input logic [brc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [brc_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic [1:0]                     cmd,
	input logic [brc_pkg::FIELD_T_W-1:0]  now_ms,
	input logic                           created_ok,
	input logic                           devices_found,
	input logic [1:0]                     error_kind,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic                           ready_res,
	input logic [1:0]                     phase,
	input logic [2:0]                     detail_code,
	input logic [brc_pkg::TALLY_W-1:0]    attempt_count,
	input logic                           factory_asked,
	input logic [brc_pkg::FIELD_T_W-1:0]  retry_at_ms
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(retry_at_ms) &&
			$stable(attempt_count) && $stable(detail_code))
		else $error("result beat changed under stall");

	// held backend and ready phase go together
	a_ready_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ready_res == (phase == brc_pkg::PH_READY)))
		else $error("ready_res and phase disagree");

	a_ready_tally: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ready_res |-> attempt_count == '0)
		else $error("attempts left over on a held backend");

	// a consuming poll ends in success exactly when the detail says so
	a_asked_detail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && factory_asked |-> (ready_res ==
			(detail_code == brc_pkg::DT_SIM_RUNNING ||
			 detail_code == brc_pkg::DT_HW_READY)))
		else $error("poll outcome and detail disagree");

endmodule

bind backoff_reconnect_controller_unit brc_chk u_brc_chk (.*);
